>>> design/mf5_pkg.sv
// Shared types and constants for the 5x5 median filter.
`timescale 1ns / 1ps

package mf5_pkg;

	// Register indexes of the configuration port.
	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int CFG_BITS      = 16;
	localparam int WIDTH_BITS    = 11;
	localparam int HEIGHT_BITS   = 16;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int MIN_DIM       = 5;

	// Median network sizes: taps, peers per tap and the rank of the median.
	localparam int WIN_TAPS      = 25;
	localparam int RANK_PEERS    = 24;
	localparam int MEDIAN_RANK   = 12;
	localparam int WIN_SIDE      = 5;
	localparam int LB_ROWS       = 4;

	// Depth of the result queue; it also bounds the items in flight.
	localparam int OUT_DEPTH     = 8;

	// Per-item flags that travel alongside the median pipeline.
	typedef struct packed {
		logic valid;
		logic emit;
		logic border;
		logic last;
	} mf5_ctrl_t;

endpackage

>>> design/mf5_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the result output.
`timescale 1ns / 1ps

interface mf5_pix_in_if #(parameter int PIXEL_BITS = 8);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_in;
	logic                  drain;

	modport source (output valid, output pixel_in, output drain, input ready);
	modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface mf5_pix_out_if #(parameter int PIXEL_BITS = 8);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_out;
	logic                  is_border;
	logic                  last_of_frame;

	modport source (output valid, output pixel_out, output is_border, output last_of_frame,
		input ready);
	modport sink   (input valid, input pixel_out, input is_border, input last_of_frame,
		output ready);
endinterface

>>> design/mf5_median.sv
// Two-stage rank-based median of a 25-tap window.
`timescale 1ns / 1ps

module mf5_median #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [mf5_pkg::WIN_TAPS*PIXEL_BITS-1:0]    win,
	input  mf5_pkg::mf5_ctrl_t                         ctrl_in,
	output mf5_pkg::mf5_ctrl_t                         ctrl_out,
	output logic [PIXEL_BITS-1:0]                      result
);

	localparam int N  = mf5_pkg::WIN_TAPS;
	localparam int RB = $clog2(N);

	logic [PIXEL_BITS-1:0] vals_s3 [N];
	logic [PIXEL_BITS-1:0] vals_s4 [N];
	logic [N-1:0]          prec_s3 [N];
	logic [RB-1:0]         rank_s4 [N];
	logic [PIXEL_BITS-1:0] center_s3, center_s4;
	mf5_pkg::mf5_ctrl_t    ctrl_s3, ctrl_s4;
	logic [N-1:0]          peer [N];
	logic [PIXEL_BITS-1:0] med;

	// Pairwise order: prec[i][j] (i < j) is set when tap j sorts ahead of tap i.
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			vals_s3[i] <= win[i*PIXEL_BITS +: PIXEL_BITS];
			for (int j = 0; j < N; j++) begin
				prec_s3[i][j] <= (j > i) ?
					(win[j*PIXEL_BITS +: PIXEL_BITS] < win[i*PIXEL_BITS +: PIXEL_BITS]) : 1'b0;
			end
		end
		center_s3 <= win[(N/2)*PIXEL_BITS +: PIXEL_BITS];
	end

	// Peers that sort ahead of each tap; ties go to the lower tap index.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				if (j < i) begin
					peer[i][j] = !prec_s3[j][i];
				end else if (j > i) begin
					peer[i][j] = prec_s3[i][j];
				end else begin
					peer[i][j] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			rank_s4[i] <= RB'($countones(peer[i]));
			vals_s4[i] <= vals_s3[i];
		end
		center_s4 <= center_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			ctrl_s3 <= ctrl_in;
			ctrl_s4 <= ctrl_s3;
		end
	end

	// Exactly one tap holds the median rank.
	always_comb begin
		med = '0;
		for (int i = 0; i < N; i++) begin
			if (rank_s4[i] == RB'(mf5_pkg::MEDIAN_RANK)) begin
				med = med | vals_s4[i];
			end
		end
	end

	assign result   = ctrl_s4.border ? center_s4 : med;
	assign ctrl_out = ctrl_s4;

endmodule

>>> design/median_filter_5x5_core.sv
// Top level of the streaming 5x5 median filter.
`timescale 1ns / 1ps

// Pixels enter on pix_in in raster order, one beat per pixel; a beat with
// drain set carries no pixel and pushes out pending results after a frame.
// Each result leaves on pix_out as a filtered pixel, a copied border pixel
// (is_border) and a frame end mark (last_of_frame). Frame size comes from
// two registers on the cfg_we / cfg_index / cfg_data write port; the user must
// write them only while the block is idle, as the block does not enforce it.
// Throughput is one beat per cycle while pix_in.ready is high: the line
// buffer memory is read in the accept cycle and written back in the cycle
// after, and consecutive beats always touch different columns. The result
// for a pixel follows the beat that completes its neighborhood (two rows plus
// two pixels later): the line buffer is read at the accepting edge, then the
// window shift, the two median stages and the queue write are each registered.
// Up to eight beats may be in flight or queued; when the receiver stalls,
// the queue fills and pix_in.ready drops once eight beats are outstanding.
// Reset clears counters, window, queue and registers (640 x 480). The line
// buffers are not cleared; no result reads a buffer entry before it is written.
module median_filter_5x5_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [mf5_pkg::CFG_BITS-1:0]  cfg_data,
	mf5_pix_in_if.sink                    pix_in,
	mf5_pix_out_if.source                 pix_out
);

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int XW  = CW + mf5_pkg::WIDTH_BITS;
	localparam int HB  = mf5_pkg::HEIGHT_BITS;
	localparam int RW  = HB + 1;
	localparam int PW  = $clog2(2 * MAX_WIDTH + 3);
	localparam int LBW = mf5_pkg::LB_ROWS * PIXEL_BITS;
	localparam int S   = mf5_pkg::WIN_SIDE;
	localparam int QA  = $clog2(mf5_pkg::OUT_DEPTH);
	localparam int QC  = $clog2(mf5_pkg::OUT_DEPTH + 1);
	localparam int RES = PIXEL_BITS + 2;

	// Configuration registers.
	logic [mf5_pkg::WIDTH_BITS-1:0] width_q;
	logic [HB-1:0]                  height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf5_pkg::WIDTH_BITS'(mf5_pkg::WIDTH_RESET);
			height_q <= HB'(mf5_pkg::HEIGHT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				mf5_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[mf5_pkg::WIDTH_BITS-1:0];
				mf5_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[HB-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size after clamping.
	logic [XW-1:0] w_raw;
	logic [CW-1:0] w_eff;
	logic [HB-1:0] h_eff;

	always_comb begin
		w_raw = XW'(width_q);
		if (w_raw < XW'(mf5_pkg::MIN_DIM)) begin
			w_eff = CW'(mf5_pkg::MIN_DIM);
		end else if (w_raw > XW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(w_raw);
		end
		h_eff = (height_q < HB'(mf5_pkg::MIN_DIM)) ? HB'(mf5_pkg::MIN_DIM) : height_q;
	end

	// Position counters and pending flush count.
	logic [CW-1:0] cc_q;
	logic [RW-1:0] rc_q;
	logic [PW-1:0] pend_q;
	logic [QC-1:0] cred_q;

	logic              accept, act, flush, emit, border, last;
	logic [CW-1:0]     cc1, col, cc_inc, cc_n;
	logic [RW-1:0]     rc1, row, rc_n;
	logic [PW-1:0]     pend_n;
	logic [CW:0]       ccol;
	logic signed [RW:0] crow;

	assign pix_in.ready = cred_q < QC'(mf5_pkg::OUT_DEPTH);
	assign accept       = pix_in.valid && pix_in.ready;

	// Input-side control: position, flush bookkeeping and border test.
	always_comb begin
		cc1   = (cc_q >= w_eff) ? '0 : cc_q;
		rc1   = (cc_q >= w_eff) ? rc_q + RW'(1) : rc_q;
		row   = (pend_q == '0 && rc1 >= RW'(h_eff)) ? '0 : rc1;
		col   = cc1;
		flush = pix_in.drain || pend_q != '0;
		act   = !(flush && pend_q == '0);

		if (col >= CW'(2)) begin
			crow = $signed({1'b0, row} - (RW+1)'(2));
			ccol = {1'b0, col} - (CW+1)'(2);
		end else begin
			crow = $signed({1'b0, row} - (RW+1)'(3));
			ccol = {1'b0, col} + {1'b0, w_eff} - (CW+1)'(2);
		end

		cc_inc = col + CW'(1);
		if (cc_inc >= w_eff) begin
			cc_n = '0;
			rc_n = row + RW'(1);
		end else begin
			cc_n = cc_inc;
			rc_n = row;
		end

		pend_n = pend_q;
		last   = 1'b0;
		if (flush) begin
			pend_n = pend_q - PW'(1);
			if (pend_n == '0) begin
				last = 1'b1;
				cc_n = '0;
				rc_n = '0;
			end
		end else if (row == RW'(h_eff) - RW'(1) && col == w_eff - CW'(1)) begin
			pend_n = PW'({w_eff, 1'b0}) + PW'(2);
		end

		emit   = flush || crow >= 0;
		border = crow < 2 || crow >= $signed({2'b00, h_eff} - (RW+1)'(2)) ||
			ccol < (CW+1)'(2) || ccol >= {1'b0, w_eff} - (CW+1)'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			rc_q   <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (act) begin
				cc_q   <= cc_n;
				rc_q   <= rc_n;
				pend_q <= pend_n;
			end else begin
				cc_q   <= cc1;
				rc_q   <= row;
			end
		end
	end

	// Stage 1 registers.
	mf5_pkg::mf5_ctrl_t    ctrl_s1, ctrl_s2;
	logic                  push_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [AW-1:0]         col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			push_s1 <= 1'b0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1.valid  <= accept;
			ctrl_s1.emit   <= accept && act && emit;
			ctrl_s1.border <= border;
			ctrl_s1.last   <= last;
			push_s1        <= accept && act;
			ctrl_s2        <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= flush ? '0 : pix_in.pixel_in;
		col_s1 <= col[AW-1:0];
	end

	// Line buffers: four earlier rows per column, read then written back.
	logic [LBW-1:0] lb_mem [MAX_WIDTH];
	logic [LBW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (accept && act) begin
			rd_q <= lb_mem[col[AW-1:0]];
		end
		if (push_s1) begin
			lb_mem[col_s1] <= {rd_q[LBW-PIXEL_BITS-1:0], pix_s1};
		end
	end

	// 5x5 window shifts left; the new column comes from the buffers and the new pixel.
	logic [PIXEL_BITS-1:0] win_q [S][S];
	logic [PIXEL_BITS-1:0] vec   [S];
	logic [mf5_pkg::WIN_TAPS*PIXEL_BITS-1:0] win_flat;

	always_comb begin
		for (int r = 0; r < S - 1; r++) begin
			vec[r] = rd_q[(S-2-r)*PIXEL_BITS +: PIXEL_BITS];
		end
		vec[S-1] = pix_s1;
		for (int r = 0; r < S; r++) begin
			for (int c = 0; c < S; c++) begin
				win_flat[(r*S+c)*PIXEL_BITS +: PIXEL_BITS] = win_q[r][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < S; r++) begin
				for (int c = 0; c < S; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (push_s1) begin
			for (int r = 0; r < S; r++) begin
				for (int c = 0; c < S - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][S-1] <= vec[r];
			end
		end
	end

	// Median network.
	mf5_pkg::mf5_ctrl_t    med_ctrl;
	logic [PIXEL_BITS-1:0] med_result;

	mf5_median #(.PIXEL_BITS(PIXEL_BITS)) u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.win      (win_flat),
		.ctrl_in  (ctrl_s2),
		.ctrl_out (med_ctrl),
		.result   (med_result)
	);

	// Result queue and credit count of beats in flight or queued.
	logic [RES-1:0] q_mem [mf5_pkg::OUT_DEPTH];
	logic [QA-1:0]  wp_q, rp_q;
	logic [QC-1:0]  qcnt_q;
	logic           q_push, q_pop, drop;

	assign q_push = med_ctrl.valid && med_ctrl.emit;
	assign drop   = med_ctrl.valid && !med_ctrl.emit;
	assign q_pop  = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk) begin
		if (q_push) begin
			q_mem[wp_q] <= {med_result, med_ctrl.border, med_ctrl.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			qcnt_q <= '0;
			cred_q <= '0;
		end else begin
			if (q_push) begin
				wp_q <= wp_q + QA'(1);
			end
			if (q_pop) begin
				rp_q <= rp_q + QA'(1);
			end
			qcnt_q <= qcnt_q + QC'(q_push) - QC'(q_pop);
			cred_q <= cred_q + QC'(accept) - QC'(q_pop) - QC'(drop);
		end
	end

	assign pix_out.valid         = qcnt_q != '0;
	assign pix_out.pixel_out     = q_mem[rp_q][RES-1:2];
	assign pix_out.is_border     = q_mem[rp_q][1];
	assign pix_out.last_of_frame = q_mem[rp_q][0];

endmodule

>>> design/mf5_checker.sv
// Port-level assertions for the median filter, bound to the top level.
`timescale 1ns / 1ps

module mf5_checker #(
	parameter int PIXEL_BITS = 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [PIXEL_BITS-1:0] pixel_out,
	input logic                  is_border,
	input logic                  last_of_frame
);

	// Beats accepted on the input that have not yet been matched by a result.
	logic [31:0] open_q;
	logic        in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 32'(in_acc) - 32'(out_acc);
		end
	end

	// A result is never delivered before the beat that caused it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (open_q != '0 || in_acc))
		else $error("result delivered without an accepted input beat");

	// The output queue is empty during reset.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid while in reset");

	// A stalled result stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// A stalled result keeps its payload.
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(pixel_out) && $stable(is_border) && $stable(last_of_frame))
		else $error("output payload changed while stalled");

endmodule

bind median_filter_5x5_core mf5_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mf5_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (pix_in.valid),
	.in_ready      (pix_in.ready),
	.out_valid     (pix_out.valid),
	.out_ready     (pix_out.ready),
	.pixel_out     (pix_out.pixel_out),
	.is_border     (pix_out.is_border),
	.last_of_frame (pix_out.last_of_frame)
);

>>> tb/tb_median_filter_5x5_core.sv
// Self-checking testbench for the streaming 5x5 median filter core.
`timescale 1ns / 1ps

module tb_median_filter_5x5_core;

	localparam int MAX_W        = 1024;
	localparam int PIX_BITS     = 8;
	localparam int SETTLE       = 12;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;

	typedef struct {
		logic [PIX_BITS-1:0] pixel;
		logic                border;
		logic                last;
	} filt_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [mf5_pkg::CFG_BITS-1:0] cfg_data;

	mf5_pix_in_if  #(.PIXEL_BITS(PIX_BITS)) in_if ();
	mf5_pix_out_if #(.PIXEL_BITS(PIX_BITS)) out_if ();

	median_filter_5x5_core #(.MAX_WIDTH(MAX_W), .PIXEL_BITS(PIX_BITS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_in   (in_if),
		.pix_out  (out_if)
	);

	// Shadow state of the filter.
	logic [4*PIX_BITS-1:0] rows_above [MAX_W];
	logic [PIX_BITS-1:0]   win [5][5];
	int col_pos, row_pos, flush_left;
	logic [mf5_pkg::WIDTH_BITS-1:0]  width_reg;
	logic [mf5_pkg::HEIGHT_BITS-1:0] height_reg;

	filt_result_t expected_q[$];
	int mismatches;
	int results_seen;
	int frames_done;
	bit no_idle;
	bit hold_req;

	// Clock.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shift one pixel into the line buffers and the window.
	task automatic shift_window(input logic [PIX_BITS-1:0] v, input int col);
		logic [4*PIX_BITS-1:0] old;
		logic [PIX_BITS-1:0] vec [5];
		old = rows_above[col];
		for (int i = 0; i < 4; i++)
			vec[3-i] = old[i*PIX_BITS +: PIX_BITS];
		vec[4] = v;
		rows_above[col] = {old[3*PIX_BITS-1:0], v};
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 4; j++)
				win[i][j] = win[i][j+1];
			win[i][4] = vec[i];
		end
	endtask

	function automatic logic [PIX_BITS-1:0] window_median();
		int v [25];
		int k, x, j;
		k = 0;
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++) begin
				v[k] = win[r][c];
				k++;
			end
		for (int i = 1; i < mf5_pkg::WIN_TAPS; i++) begin
			x = v[i];
			j = i - 1;
			while (j >= 0 && v[j] > x) begin
				v[j+1] = v[j];
				j--;
			end
			v[j+1] = x;
		end
		return PIX_BITS'(v[mf5_pkg::MEDIAN_RANK]);
	endfunction

	// Advance the shadow filter by one accepted beat and queue any result.
	task automatic predict_filter(input logic [PIX_BITS-1:0] pix, input logic drn);
		int w, h, col, row, crow, ccol;
		bit flush, last, border;
		filt_result_t r;
		w = width_reg;
		h = height_reg;
		last = 0;
		if (w < mf5_pkg::MIN_DIM) w = mf5_pkg::MIN_DIM;
		if (w > MAX_W) w = MAX_W;
		if (h < mf5_pkg::MIN_DIM) h = mf5_pkg::MIN_DIM;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (flush_left == 0 && row_pos >= h) row_pos = 0;
		flush = drn || flush_left > 0;
		if (flush && flush_left == 0) return;
		col = col_pos;
		row = row_pos;
		shift_window(flush ? '0 : pix, col);
		if (col >= 2) begin
			crow = row - 2;
			ccol = col - 2;
		end else begin
			crow = row - 3;
			ccol = col + w - 2;
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (flush) begin
			flush_left--;
			if (flush_left == 0) begin
				last = 1;
				col_pos = 0;
				row_pos = 0;
			end
		end else begin
			if (row == h - 1 && col == w - 1) flush_left = 2 * w + 2;
			if (crow < 0) return;
		end
		border = crow < 2 || crow >= h - 2 || ccol < 2 || ccol >= w - 2;
		r.pixel = border ? win[2][2] : window_median();
		r.border = border;
		r.last = last;
		expected_q.push_back(r);
	endtask

	// Send one beat on the pixel input after a random gap, or none when no_idle is set.
	task automatic send_beat(input logic [PIX_BITS-1:0] pix, input logic drn);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			@(negedge clk);
			in_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_if.valid    <= 1'b1;
		in_if.pixel_in <= pix;
		in_if.drain    <= drn;
		do @(posedge clk); while (!in_if.ready);
		predict_filter(pix, drn);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [mf5_pkg::CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == mf5_pkg::REG_IMAGE_WIDTH) width_reg = val[mf5_pkg::WIDTH_BITS-1:0];
		else height_reg = val[mf5_pkg::HEIGHT_BITS-1:0];
	endtask

	// Let every expected result arrive, then let the pipeline settle.
	task automatic wait_idle();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [PIX_BITS-1:0] rand_pixel();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			1: return 8'(($urandom_range(0, 3)) * 85);
			default: return 8'($urandom);
		endcase
	endfunction

	// One frame of pixels followed by its flush; noise adds stray beats.
	task automatic run_frame(input int w, input int h, input bit noise);
		for (int i = 0; i < w * h; i++)
			send_beat(rand_pixel(), 1'b0);
		for (int i = 0; i < 2 * w + 2; i++)
			send_beat(rand_pixel(), (noise && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1);
		if (noise) send_beat(rand_pixel(), 1'b1);
		frames_done++;
	endtask

	task automatic test_directed_small();
		write_reg(mf5_pkg::REG_IMAGE_WIDTH, 16'd5);
		write_reg(mf5_pkg::REG_IMAGE_HEIGHT, 16'd5);
		// A drain with nothing pending is ignored.
		send_beat(8'hA5, 1'b1);
		for (int i = 0; i < 25; i++)
			send_beat((i % 2) ? 8'hFF : 8'h00, 1'b0);
		// Pixels during the flush count as drain beats.
		for (int i = 0; i < 12; i++)
			send_beat(8'h5A, (i % 3) == 0 ? 1'b0 : 1'b1);
		frames_done++;
		wait_idle();
	endtask

	task automatic test_clamped_low();
		write_reg(mf5_pkg::REG_IMAGE_WIDTH, 16'd0);
		write_reg(mf5_pkg::REG_IMAGE_HEIGHT, 16'd0);
		run_frame(5, 5, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int w, h;
		for (int f = 0; f < 6; f++) begin
			w = $urandom_range(5, 12);
			h = $urandom_range(5, 8);
			write_reg(mf5_pkg::REG_IMAGE_WIDTH, 16'(w));
			write_reg(mf5_pkg::REG_IMAGE_HEIGHT, 16'(h));
			no_idle = (f % 3 == 2);
			run_frame(w, h, 1'b1);
			wait_idle();
		end
		no_idle = 0;
	endtask

	task automatic test_backpressure();
		write_reg(mf5_pkg::REG_IMAGE_WIDTH, 16'd7);
		write_reg(mf5_pkg::REG_IMAGE_HEIGHT, 16'd6);
		no_idle = 1;
		hold_req = 1;
		run_frame(7, 6, 1'b0);
		no_idle = 0;
		wait_idle();
	endtask

	task automatic test_tall_partial();
		write_reg(mf5_pkg::REG_IMAGE_WIDTH, 16'd5);
		write_reg(mf5_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
		for (int i = 0; i < 20; i++)
			send_beat(rand_pixel(), 1'b0);
		wait_idle();
		// Shrinking the height finishes the frame two rows later.
		write_reg(mf5_pkg::REG_IMAGE_HEIGHT, 16'd6);
		for (int i = 0; i < 10; i++)
			send_beat(rand_pixel(), 1'b0);
		for (int i = 0; i < 12; i++)
			send_beat(8'h00, 1'b1);
		frames_done++;
		wait_idle();
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			if (hold_req) begin
				hold_req = 0;
				@(negedge clk);
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				@(negedge clk);
				out_if.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_if.ready <= 1'b1;
			do @(posedge clk); while (!(out_if.valid && out_if.ready));
		end
	end

	// Compare each result beat against the oldest expectation.
	always @(posedge clk) begin
		filt_result_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: pixel %0d border %0b last %0b",
						out_if.pixel_out, out_if.is_border, out_if.last_of_frame);
			end else begin
				e = expected_q.pop_front();
				if (out_if.pixel_out !== e.pixel || out_if.is_border !== e.border
						|| out_if.last_of_frame !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected pixel %0d border %0b last %0b, got %0d %0b %0b",
							results_seen, e.pixel, e.border, e.last,
							out_if.pixel_out, out_if.is_border, out_if.last_of_frame);
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either side.
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[median_filter_5x5_core] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.pixel_in = '0;
		in_if.drain = 1'b0;
		mismatches = 0;
		results_seen = 0;
		frames_done = 0;
		no_idle = 0;
		hold_req = 0;
		width_reg = mf5_pkg::WIDTH_BITS'(mf5_pkg::WIDTH_RESET);
		height_reg = mf5_pkg::HEIGHT_BITS'(mf5_pkg::HEIGHT_RESET);
		col_pos = 0;
		row_pos = 0;
		flush_left = 0;
		for (int i = 0; i < MAX_W; i++) rows_above[i] = '0;
		for (int r = 0; r < 5; r++)
			for (int c = 0; c < 5; c++) win[r][c] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		test_directed_small();
		test_clamped_low();
		test_random_frames();
		test_backpressure();
		test_tall_partial();

		wait_idle();
		$display("Covered %0d frames and %0d result beats: clamped and odd frame sizes,",
			frames_done, results_seen);
		$display("stray pixels and drains, a height change mid-frame and a long output stall.");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("[median_filter_5x5_core] OK");
		end else begin
			$display("[median_filter_5x5_core] ERROR");
		end
		$finish;
	end

endmodule

>>> median_filter_5x5_core.f
design/mf5_pkg.sv
design/mf5_stream_if.sv
design/mf5_median.sv
design/median_filter_5x5_core.sv
design/mf5_checker.sv
tb/tb_median_filter_5x5_core.sv
